@@ src/cpic_pkg.sv @@
package cpic_pkg;

   localparam int WORD_W  = 32;
   localparam int FRAC_W  = 16;
   localparam int CFG_W   = FRAC_W + 1;
   localparam int RAD_W   = 31;
   localparam int DIFF_W  = WORD_W + 1;
   localparam int RSUM_W  = RAD_W + 1;
   localparam int RSQ_W   = 2 * RSUM_W;
   localparam int SQ_W    = 2 * DIFF_W;
   localparam int DOT_W   = SQ_W + 1;
   localparam int MAG_W   = SQ_W;
   localparam int HALF_W  = DIFF_W;
   localparam int E_W     = CFG_W + 1;
   localparam int COEF_W  = E_W + RAD_W;
   localparam int KLO_W   = 25;
   localparam int KHI_W   = COEF_W - KLO_W;
   localparam int A_W     = MAG_W + DIFF_W;
   localparam int A_CHUNKS = 3;
   localparam int PP_W    = HALF_W + KLO_W;
   localparam int PART_W  = A_W + KLO_W;
   localparam int NUM_W   = A_W + COEF_W;
   localparam int DNP_W   = RSUM_W + HALF_W;
   localparam int DEN_W   = RSUM_W + SQ_W + FRAC_W;
   localparam int Q_W     = 36;
   localparam int REM_W   = NUM_W + 2;
   localparam int SUM_W   = Q_W + 2;
   localparam int LANES   = 4;
   localparam int PRE_STAGES = 9;

   localparam logic [CFG_W-1:0] RESTITUTION_RESET = CFG_W'(1 << FRAC_W);
   localparam logic [E_W-1:0]   E_ONE             = E_W'(1 << FRAC_W);

   typedef struct packed {
      logic signed [WORD_W-1:0] first_pos_x;
      logic signed [WORD_W-1:0] first_pos_y;
      logic signed [WORD_W-1:0] second_pos_x;
      logic signed [WORD_W-1:0] second_pos_y;
      logic signed [WORD_W-1:0] first_vel_x;
      logic signed [WORD_W-1:0] first_vel_y;
      logic signed [WORD_W-1:0] second_vel_x;
      logic signed [WORD_W-1:0] second_vel_y;
      logic [RAD_W-1:0]         first_radius;
      logic [RAD_W-1:0]         second_radius;
      logic [RAD_W-1:0]         first_mass;
      logic [RAD_W-1:0]         second_mass;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] new_first_vel_x;
      logic signed [WORD_W-1:0] new_first_vel_y;
      logic signed [WORD_W-1:0] new_second_vel_x;
      logic signed [WORD_W-1:0] new_second_vel_y;
      logic                     responded;
   } rsp_type;

   typedef struct packed {
      logic [LANES-1:0][WORD_W-1:0] vel;
      logic                         hit;
      logic [LANES-1:0]             neg;
   } side_type;

   function automatic logic [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'({1'b0, {(WORD_W-1){1'b1}}});
      lo = -hi - SUM_W'(1);
      if (v > hi) begin
         return {1'b0, {(WORD_W-1){1'b1}}};
      end else if (v < lo) begin
         return {1'b1, {(WORD_W-1){1'b0}}};
      end
      return v[WORD_W-1:0];
   endfunction

endpackage

@@ src/cpic_divider.sv @@
module cpic_divider
   import cpic_pkg::*;
(
   input  logic              clock,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   output logic [Q_W-1:0]    quot
);

   logic [REM_W-1:0] rem_ff  [Q_W-1];
   logic [DEN_W-1:0] den_ff  [Q_W-1];
   logic [Q_W-1:0]   quot_ff [Q_W];
   logic [REM_W-1:0] rem_in  [Q_W];
   logic [Q_W-1:0]   quot_in [Q_W];

   // one quotient bit per stage, most significant first
   for (genvar j = 0; j < Q_W; j++) begin : g_stage
      logic [REM_W-1:0] r_src;
      logic [REM_W-1:0] shifted;
      logic [DEN_W-1:0] d_src;
      logic [Q_W-1:0]   q_src;
      logic             ge;

      if (j == 0) begin : g_first
         assign r_src = REM_W'(num);
         assign d_src = den;
         assign q_src = '0;
      end else begin : g_next
         assign r_src = rem_ff[j-1];
         assign d_src = den_ff[j-1];
         assign q_src = quot_ff[j-1];
      end

      assign shifted    = REM_W'(d_src) << (Q_W - 1 - j);
      assign ge         = r_src >= shifted;
      assign rem_in[j]  = ge ? r_src - shifted : r_src;
      assign quot_in[j] = ge ? (q_src | (Q_W'(1) << (Q_W - 1 - j))) : q_src;

      always_ff @(posedge clock) begin
         quot_ff[j] <= quot_in[j];
      end

      if (j < Q_W - 1) begin : g_hold
         always_ff @(posedge clock) begin
            rem_ff[j] <= rem_in[j];
            den_ff[j] <= d_src;
         end
      end
   end

   assign quot = quot_ff[Q_W-1];

endmodule

@@ src/circle_pair_impulse_collision.sv @@
// Two-disc collision response along the line of centres, with restitution.
// Issue a pair of discs on req_data with start; busy stays low, so a new
// transaction is taken every cycle. The result leaves on rsp_data with the
// one-cycle strobe rsp_valid after the accepting edge, having passed through
// nine arithmetic stages (differences, squares, sums, partial products of
// the numerator and denominator) followed by a 36-stage restoring divider,
// one quotient bit per stage, and the output register. Throughput is one
// pair per cycle at any fill level.
// responded is set when the discs overlap, have distinct centres, a nonzero
// mass sum, and are not moving apart; otherwise the velocities pass through.
// The restitution coefficient is written through csr_valid/csr_data
// (csr_ready is always high); write it only while no transaction is in
// flight. Synchronous reset clears the pipeline valid bits and sets the
// coefficient to 1.0. The receiver cannot stall: each result is presented
// for exactly one cycle.
module circle_pair_impulse_collision
   import cpic_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_data
);

   logic [CFG_W-1:0] restitution_ff;

   logic             valid_ff [PRE_STAGES];
   side_type         side_ff  [PRE_STAGES];
   side_type         side_in  [PRE_STAGES];

   // stage 1
   logic signed [DIFF_W-1:0] s1_dx_ff, s1_dy_ff, s1_rvx_ff, s1_rvy_ff;
   logic signed [DIFF_W-1:0] s1_dx_in, s1_dy_in, s1_rvx_in, s1_rvy_in;
   logic [RSUM_W-1:0]        s1_rsum_ff, s1_msum_ff, s1_rsum_in, s1_msum_in;
   logic [COEF_W-1:0]        s1_k1_ff, s1_k2_ff, s1_k1_in, s1_k2_in;
   logic [E_W-1:0]           e_val;
   // stage 2
   logic signed [SQ_W-1:0]   s2_dxx_ff, s2_dyy_ff, s2_dxr_ff, s2_dyr_ff;
   logic signed [SQ_W-1:0]   s2_dxx_in, s2_dyy_in, s2_dxr_in, s2_dyr_in;
   logic [RSQ_W-1:0]         s2_rs2_ff, s2_rs2_in;
   logic [DIFF_W-1:0]        s2_adx_ff, s2_ady_ff, s2_adx_in, s2_ady_in;
   logic                     s2_dxn_ff, s2_dyn_ff;
   logic [RSUM_W-1:0]        s2_msum_ff;
   logic [COEF_W-1:0]        s2_k1_ff, s2_k2_ff;
   // stage 3
   logic [SQ_W-1:0]          s3_dd_ff, s3_dd_in;
   logic signed [DOT_W-1:0]  s3_dot_ff, s3_dot_in;
   logic [RSQ_W-1:0]         s3_rs2_ff;
   logic [DIFF_W-1:0]        s3_adx_ff, s3_ady_ff;
   logic                     s3_dxn_ff, s3_dyn_ff;
   logic [RSUM_W-1:0]        s3_msum_ff;
   logic [COEF_W-1:0]        s3_k1_ff, s3_k2_ff;
   // stage 4
   logic [MAG_W-1:0]         s4_a_ff, s4_a_in;
   logic [SQ_W-1:0]          s4_dd_ff;
   logic [DIFF_W-1:0]        s4_adx_ff, s4_ady_ff;
   logic [RSUM_W-1:0]        s4_msum_ff;
   logic [COEF_W-1:0]        s4_k1_ff, s4_k2_ff;
   // stage 5
   logic [SQ_W-1:0]          s5_axl_ff, s5_axh_ff, s5_ayl_ff, s5_ayh_ff;
   logic [SQ_W-1:0]          s5_axl_in, s5_axh_in, s5_ayl_in, s5_ayh_in;
   logic [DNP_W-1:0]         s5_dnl_ff, s5_dnh_ff, s5_dnl_in, s5_dnh_in;
   logic [COEF_W-1:0]        s5_k1_ff, s5_k2_ff;
   // stage 6
   logic [A_W-1:0]           s6_ax_ff, s6_ay_ff, s6_ax_in, s6_ay_in;
   logic [DEN_W-1:0]         s6_dn_ff, s6_dn_in;
   logic [COEF_W-1:0]        s6_k1_ff, s6_k2_ff;
   // stage 7
   logic [PP_W-1:0]          s7_pp_ff [LANES][A_CHUNKS][2];
   logic [PP_W-1:0]          s7_pp_in [LANES][A_CHUNKS][2];
   logic [DEN_W-1:0]         s7_dn_ff;
   // stage 8
   logic [PART_W-1:0]        s8_part_ff [LANES][2];
   logic [PART_W-1:0]        s8_part_in [LANES][2];
   logic [DEN_W-1:0]         s8_dn_ff;
   // stage 9
   logic [NUM_W-1:0]         s9_num_ff [LANES];
   logic [NUM_W-1:0]         s9_num_in [LANES];
   logic [DEN_W-1:0]         s9_dn_ff;

   logic [Q_W-1:0]           quot [LANES];
   logic                     dly_valid_ff [Q_W];
   side_type                 dly_side_ff  [Q_W];

   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff, rsp_in;

   function automatic logic [HALF_W-1:0] s7_chunk(input logic [A_W-1:0] a, input int i);
      return HALF_W'(a >> (HALF_W * i));
   endfunction

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         restitution_ff <= RESTITUTION_RESET;
      end else if (csr_valid) begin
         restitution_ff <= csr_data;
      end
   end

   // stage 1: differences, sums, mass coefficients
   always_comb begin
      s1_dx_in   = DIFF_W'(req_data.second_pos_x) - DIFF_W'(req_data.first_pos_x);
      s1_dy_in   = DIFF_W'(req_data.second_pos_y) - DIFF_W'(req_data.first_pos_y);
      s1_rvx_in  = DIFF_W'(req_data.second_vel_x) - DIFF_W'(req_data.first_vel_x);
      s1_rvy_in  = DIFF_W'(req_data.second_vel_y) - DIFF_W'(req_data.first_vel_y);
      s1_rsum_in = RSUM_W'(req_data.first_radius) + RSUM_W'(req_data.second_radius);
      s1_msum_in = RSUM_W'(req_data.first_mass) + RSUM_W'(req_data.second_mass);
      e_val      = E_W'(restitution_ff) + E_ONE;
      s1_k1_in   = COEF_W'(e_val) * COEF_W'(req_data.second_mass);
      s1_k2_in   = COEF_W'(e_val) * COEF_W'(req_data.first_mass);
      side_in[0].vel[0] = req_data.first_vel_x;
      side_in[0].vel[1] = req_data.first_vel_y;
      side_in[0].vel[2] = req_data.second_vel_x;
      side_in[0].vel[3] = req_data.second_vel_y;
      side_in[0].hit    = 1'b0;
      side_in[0].neg    = '0;
   end

   always_ff @(posedge clock) begin
      s1_dx_ff   <= s1_dx_in;
      s1_dy_ff   <= s1_dy_in;
      s1_rvx_ff  <= s1_rvx_in;
      s1_rvy_ff  <= s1_rvy_in;
      s1_rsum_ff <= s1_rsum_in;
      s1_msum_ff <= s1_msum_in;
      s1_k1_ff   <= s1_k1_in;
      s1_k2_ff   <= s1_k2_in;
   end

   // stage 2: squares and dot terms
   always_comb begin
      s2_dxx_in = SQ_W'(s1_dx_ff) * SQ_W'(s1_dx_ff);
      s2_dyy_in = SQ_W'(s1_dy_ff) * SQ_W'(s1_dy_ff);
      s2_dxr_in = SQ_W'(s1_dx_ff) * SQ_W'(s1_rvx_ff);
      s2_dyr_in = SQ_W'(s1_dy_ff) * SQ_W'(s1_rvy_ff);
      s2_rs2_in = RSQ_W'(s1_rsum_ff) * RSQ_W'(s1_rsum_ff);
      s2_adx_in = s1_dx_ff[DIFF_W-1] ? DIFF_W'(-s1_dx_ff) : DIFF_W'(s1_dx_ff);
      s2_ady_in = s1_dy_ff[DIFF_W-1] ? DIFF_W'(-s1_dy_ff) : DIFF_W'(s1_dy_ff);
      side_in[1] = side_ff[0];
   end

   always_ff @(posedge clock) begin
      s2_dxx_ff  <= s2_dxx_in;
      s2_dyy_ff  <= s2_dyy_in;
      s2_dxr_ff  <= s2_dxr_in;
      s2_dyr_ff  <= s2_dyr_in;
      s2_rs2_ff  <= s2_rs2_in;
      s2_adx_ff  <= s2_adx_in;
      s2_ady_ff  <= s2_ady_in;
      s2_dxn_ff  <= s1_dx_ff[DIFF_W-1];
      s2_dyn_ff  <= s1_dy_ff[DIFF_W-1];
      s2_msum_ff <= s1_msum_ff;
      s2_k1_ff   <= s1_k1_ff;
      s2_k2_ff   <= s1_k2_ff;
   end

   // stage 3: squared distance and dot product
   always_comb begin
      s3_dd_in   = SQ_W'($unsigned(s2_dxx_ff)) + SQ_W'($unsigned(s2_dyy_ff));
      s3_dot_in  = DOT_W'(s2_dxr_ff) + DOT_W'(s2_dyr_ff);
      side_in[2] = side_ff[1];
   end

   always_ff @(posedge clock) begin
      s3_dd_ff   <= s3_dd_in;
      s3_dot_ff  <= s3_dot_in;
      s3_rs2_ff  <= s2_rs2_ff;
      s3_adx_ff  <= s2_adx_ff;
      s3_ady_ff  <= s2_ady_ff;
      s3_dxn_ff  <= s2_dxn_ff;
      s3_dyn_ff  <= s2_dyn_ff;
      s3_msum_ff <= s2_msum_ff;
      s3_k1_ff   <= s2_k1_ff;
      s3_k2_ff   <= s2_k2_ff;
   end

   // stage 4: decide the response, take the approach speed magnitude
   always_comb begin
      side_in[3]     = side_ff[2];
      side_in[3].hit = (s3_dd_ff <= SQ_W'(s3_rs2_ff)) && (s3_dd_ff != '0)
                       && (s3_dot_ff[DOT_W-1] || (s3_dot_ff == '0))
                       && (s3_msum_ff != '0);
      // the dot product is not positive here, so the change opposes d for the first disc and follows d for the second
      side_in[3].neg[0] = !s3_dxn_ff;
      side_in[3].neg[1] = !s3_dyn_ff;
      side_in[3].neg[2] = s3_dxn_ff;
      side_in[3].neg[3] = s3_dyn_ff;
      s4_a_in = MAG_W'(-s3_dot_ff);
   end

   always_ff @(posedge clock) begin
      s4_a_ff    <= s4_a_in;
      s4_dd_ff   <= s3_dd_ff;
      s4_adx_ff  <= s3_adx_ff;
      s4_ady_ff  <= s3_ady_ff;
      s4_msum_ff <= s3_msum_ff;
      s4_k1_ff   <= s3_k1_ff;
      s4_k2_ff   <= s3_k2_ff;
   end

   // stage 5: split products
   always_comb begin
      s5_axl_in = SQ_W'(s4_a_ff[HALF_W-1:0]) * SQ_W'(s4_adx_ff);
      s5_axh_in = SQ_W'(s4_a_ff[MAG_W-1:HALF_W]) * SQ_W'(s4_adx_ff);
      s5_ayl_in = SQ_W'(s4_a_ff[HALF_W-1:0]) * SQ_W'(s4_ady_ff);
      s5_ayh_in = SQ_W'(s4_a_ff[MAG_W-1:HALF_W]) * SQ_W'(s4_ady_ff);
      s5_dnl_in = DNP_W'(s4_msum_ff) * DNP_W'(s4_dd_ff[HALF_W-1:0]);
      s5_dnh_in = DNP_W'(s4_msum_ff) * DNP_W'(s4_dd_ff[SQ_W-1:HALF_W]);
      side_in[4] = side_ff[3];
   end

   always_ff @(posedge clock) begin
      s5_axl_ff <= s5_axl_in;
      s5_axh_ff <= s5_axh_in;
      s5_ayl_ff <= s5_ayl_in;
      s5_ayh_ff <= s5_ayh_in;
      s5_dnl_ff <= s5_dnl_in;
      s5_dnh_ff <= s5_dnh_in;
      s5_k1_ff  <= s4_k1_ff;
      s5_k2_ff  <= s4_k2_ff;
   end

   // stage 6: combine halves, scale the denominator by one
   always_comb begin
      s6_ax_in = A_W'(s5_axl_ff) + (A_W'(s5_axh_ff) << HALF_W);
      s6_ay_in = A_W'(s5_ayl_ff) + (A_W'(s5_ayh_ff) << HALF_W);
      s6_dn_in = (DEN_W'(s5_dnl_ff) + (DEN_W'(s5_dnh_ff) << HALF_W)) << FRAC_W;
      side_in[5] = side_ff[4];
   end

   always_ff @(posedge clock) begin
      s6_ax_ff <= s6_ax_in;
      s6_ay_ff <= s6_ay_in;
      s6_dn_ff <= s6_dn_in;
      s6_k1_ff <= s5_k1_ff;
      s6_k2_ff <= s5_k2_ff;
   end

   // stage 7: numerator partial products per lane
   always_comb begin
      logic [A_W-1:0]    a_sel;
      logic [COEF_W-1:0] k_sel;
      logic [HALF_W-1:0] a_chunk;
      for (int n = 0; n < LANES; n++) begin
         a_sel = n[0] ? s6_ay_ff : s6_ax_ff;
         k_sel = n[1] ? s6_k2_ff : s6_k1_ff;
         for (int i = 0; i < A_CHUNKS; i++) begin
            a_chunk = s7_chunk(a_sel, i);
            s7_pp_in[n][i][0] = PP_W'(a_chunk) * PP_W'(k_sel[KLO_W-1:0]);
            s7_pp_in[n][i][1] = PP_W'(a_chunk) * PP_W'(k_sel[COEF_W-1:KLO_W]);
         end
      end
      side_in[6] = side_ff[5];
   end

   always_ff @(posedge clock) begin
      s7_pp_ff <= s7_pp_in;
      s7_dn_ff <= s6_dn_ff;
   end

   // stage 8: sum partials per coefficient chunk
   always_comb begin
      for (int n = 0; n < LANES; n++) begin
         for (int j = 0; j < 2; j++) begin
            s8_part_in[n][j] = PART_W'(s7_pp_ff[n][0][j])
                             + (PART_W'(s7_pp_ff[n][1][j]) << HALF_W)
                             + (PART_W'(s7_pp_ff[n][2][j]) << (2 * HALF_W));
         end
      end
      side_in[7] = side_ff[6];
   end

   always_ff @(posedge clock) begin
      s8_part_ff <= s8_part_in;
      s8_dn_ff   <= s7_dn_ff;
   end

   // stage 9: full numerator magnitude
   always_comb begin
      for (int n = 0; n < LANES; n++) begin
         s9_num_in[n] = NUM_W'(s8_part_ff[n][0]) + (NUM_W'(s8_part_ff[n][1]) << KLO_W);
      end
      side_in[8] = side_ff[7];
   end

   always_ff @(posedge clock) begin
      s9_num_ff <= s9_num_in;
      s9_dn_ff  <= s8_dn_ff;
   end

   always_ff @(posedge clock) begin
      side_ff <= side_in;
      if (reset) begin
         for (int k = 0; k < PRE_STAGES; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= start;
         for (int k = 1; k < PRE_STAGES; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   for (genvar n = 0; n < LANES; n++) begin : g_lane
      cpic_divider u_divider (
         .clock (clock),
         .num   (s9_num_ff[n]),
         .den   (s9_dn_ff),
         .quot  (quot[n])
      );
   end

   // sideband travels alongside the divider
   always_ff @(posedge clock) begin
      dly_side_ff[0] <= side_ff[PRE_STAGES-1];
      for (int k = 1; k < Q_W; k++) begin
         dly_side_ff[k] <= dly_side_ff[k-1];
      end
      if (reset) begin
         for (int k = 0; k < Q_W; k++) begin
            dly_valid_ff[k] <= 1'b0;
         end
      end else begin
         dly_valid_ff[0] <= valid_ff[PRE_STAGES-1];
         for (int k = 1; k < Q_W; k++) begin
            dly_valid_ff[k] <= dly_valid_ff[k-1];
         end
      end
   end

   // apply signed change, saturate, or pass through
   always_comb begin
      logic [LANES-1:0][WORD_W-1:0] res;
      logic signed [SUM_W-1:0]      q_s;
      logic signed [SUM_W-1:0]      sum;
      side_type                     sd;
      sd = dly_side_ff[Q_W-1];
      for (int n = 0; n < LANES; n++) begin
         q_s = sd.neg[n] ? -SUM_W'(quot[n]) : SUM_W'(quot[n]);
         sum = SUM_W'($signed(sd.vel[n])) + q_s;
         res[n] = sd.hit ? sat_word(sum) : sd.vel[n];
      end
      rsp_in.new_first_vel_x  = res[0];
      rsp_in.new_first_vel_y  = res[1];
      rsp_in.new_second_vel_x = res[2];
      rsp_in.new_second_vel_y = res[3];
      rsp_in.responded        = sd.hit;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dly_valid_ff[Q_W-1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
